### rtl/core/bspc_pkg.sv
// Shared types, codes and constants for the bitmap scale/pack chunker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bspc_pkg;

    localparam int STORE_DEPTH = 8192;
    localparam int STORE_AW    = 13;
    localparam int CFG_W       = 16;
    localparam int DIV_W       = 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PULL  = 2'd2;

    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_SCALE_REQUEST = 3'd2;
    localparam logic [2:0] CFG_CENTER_ENABLE = 3'd3;
    localparam logic [2:0] CFG_PRINT_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_PACKAGE_LIMIT = 3'd5;

    localparam logic [7:0] HDR_DC2  = 8'h12;
    localparam logic [7:0] HDR_STAR = 8'h2A;
    localparam logic [2:0] HDR_LEN  = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [12:0] load_address;
        logic [7:0]  load_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       run_done;
    } out_item_t;

    typedef struct packed {
        logic mem_write;
        logic div_start;
        logic div_pkg;
        logic run_scale;
        logic run_mult;
        logic run_geom;
        logic run_rowb;
        logic run_pkg;
        logic emit_idle;
        logic emit_header;
        logic row_base;
        logic dot_step;
        logic dot_finish;
    } bspc_cmd_t;

    typedef struct packed {
        logic run_active;
        logic header_due;
        logic out_full;
        logic div_busy;
        logic need_read;
        logic byte_done;
    } bspc_stat_t;

endpackage

### rtl/core/bitmap_scale_pack_chunker.sv
// Top level of the bitmap scale/pack chunker: controller plus datapath.
// Depends on bspc_pkg, bspc_ctrl, bspc_dp (which holds bspc_div).
`timescale 1ns / 1ps

// Usage
//   Input beats (in_valid/in_ready, in_data) carry an opcode: load writes one
//   bitmap byte into the 8192-byte store, start fixes the print geometry and
//   restarts the run, pull asks for the next printer stream byte. Only a pull
//   gives an output beat (out_valid/out_ready, out_data).
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data), to be
//   written by the user while no beat is in flight; the block does not check.
// Timing
//   load and unused opcodes: accepted back to back.
//   start: sets up the geometry with two passes through the 16-step serial
//   divider (printer width / image width, package limit / row bytes).
//   pull: header and idle beats are registered once the output register is free;
//   a data byte walks its dots after the row base step, a pixel dot taking an extra
//   wait state for the single read port of the store and its read register.
// Reset and stall
//   Reset clears all control state and loads the register defaults; the
//   store content is undefined until loaded. One output register sits between
//   the sides: loads and starts are still taken while a result waits, and a
//   further pull holds until the waiting result has been taken.

module bitmap_scale_pack_chunker
    import bspc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    bspc_cmd_t  cmd;
    bspc_stat_t stat;

    bspc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_data.opcode),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bspc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/core/bspc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bspc_pkg.
`timescale 1ns / 1ps

module bspc_div
    import bspc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   diff;

    assign rem_shift = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/bspc_dp.sv
// Datapath: configuration registers, bitmap store, geometry, dot walker, output register.
// Depends on bspc_pkg and bspc_div.
`timescale 1ns / 1ps

module bspc_dp
    import bspc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bspc_cmd_t        cmd,
    output bspc_stat_t       stat,
    input  in_item_t         in_data,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    // configuration
    logic [11:0] img_w_reg, img_h_reg, print_w_reg;
    logic [7:0]  scale_req_reg;
    logic        center_reg;
    logic [15:0] pkg_limit_reg;

    // geometry fixed at start
    logic [11:0] scale_reg, sw_reg, printed_reg;
    logic [10:0] margin_reg;
    logic [9:0]  row_bytes_reg;
    logic [15:0] pkg_bytes_reg, pkg_rows_reg, rows_rem_reg;

    // walk state
    logic [11:0] src_row_reg, row_rep_reg, src_col_reg, col_rep_reg, row_dot_reg;
    logic [10:0] margin_cnt_reg;
    logic        margin_done_reg;
    logic [7:0]  pack_reg;
    logic [2:0]  bit_off_reg;
    logic [15:0] fill_reg;
    logic [2:0]  hdr_phase_reg;
    logic        active_reg;
    logic [23:0] row_base_reg;

    logic [7:0]  store [STORE_DEPTH];
    logic [7:0]  rd_data_reg;
    logic [2:0]  rd_sel_reg;

    logic        out_valid_reg;
    out_item_t   out_data_reg;

    // divider
    logic [DIV_W-1:0] div_q;
    logic             div_busy;
    logic [DIV_W-1:0] div_a, div_b;

    assign div_a = cmd.div_pkg ? pkg_limit_reg : {4'b0, print_w_reg};
    assign div_b = cmd.div_pkg ? {6'b0, row_bytes_reg} : {4'b0, img_w_reg};

    bspc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // start-up arithmetic
    logic [11:0] maxs, scale_calc;
    logic [23:0] sw_prod, tot_prod;
    logic [11:0] pw_diff;
    logic [10:0] margin_calc;
    logic [12:0] rb_sum;
    logic [15:0] prow_q, prow;
    logic [25:0] pkg_prod;

    assign maxs       = (img_w_reg == 12'd0) ? 12'd0 : div_q[11:0];
    assign scale_calc = (scale_req_reg == 8'd0 || {4'b0, scale_req_reg} > maxs)
                        ? maxs : {4'b0, scale_req_reg};
    assign sw_prod    = scale_reg * img_w_reg;
    assign tot_prod   = img_h_reg * scale_reg;
    assign pw_diff    = print_w_reg - sw_reg;
    assign margin_calc = center_reg ? pw_diff[11:1] : 11'd0;
    assign rb_sum     = {1'b0, printed_reg} + 13'd7;
    assign prow_q     = (row_bytes_reg == 10'd0) ? 16'd1 : div_q;
    assign prow       = (prow_q == 16'd0) ? 16'd1 : prow_q;
    assign pkg_prod   = prow * row_bytes_reg;

    // dot walker
    logic        in_margin, col_past, need_read, dot, row_end, row_wrap, col_wrap;
    logic        byte_done, last, finishing, pkg_end;
    logic [24:0] bit_idx;
    logic [12:0] row_dot_inc, row_rep_inc, col_rep_inc;
    logic [11:0] src_row_new;
    logic [7:0]  pack_new;
    logic [16:0] fill_inc;
    logic [15:0] hdr_rows;
    logic [7:0]  hdr_byte;

    assign in_margin   = !margin_done_reg && (margin_cnt_reg < margin_reg);
    assign col_past    = src_col_reg >= img_w_reg;
    assign need_read   = !in_margin && !col_past;
    assign bit_idx     = {1'b0, row_base_reg} + {13'b0, src_col_reg};
    assign dot         = cmd.dot_finish ? rd_data_reg[~rd_sel_reg] : 1'b0;
    assign pack_new    = pack_reg | ({7'b0, dot} << bit_off_reg);
    assign row_dot_inc = {1'b0, row_dot_reg} + 13'd1;
    assign row_end     = row_dot_inc >= {1'b0, printed_reg};
    assign row_rep_inc = {1'b0, row_rep_reg} + 13'd1;
    assign row_wrap    = row_rep_inc >= {1'b0, scale_reg};
    assign col_rep_inc = {1'b0, col_rep_reg} + 13'd1;
    assign col_wrap    = col_rep_inc >= {1'b0, scale_reg};
    assign src_row_new = row_wrap ? src_row_reg + 12'd1 : src_row_reg;
    assign last        = row_end && (src_row_new >= img_h_reg);
    assign byte_done   = row_end || (bit_off_reg == 3'd0);
    assign finishing   = cmd.dot_finish || (cmd.dot_step && !need_read);
    assign fill_inc    = {1'b0, fill_reg} + 17'd1;
    assign pkg_end     = fill_inc >= {1'b0, pkg_bytes_reg};
    assign hdr_rows    = (pkg_rows_reg < rows_rem_reg) ? pkg_rows_reg : rows_rem_reg;

    always_comb
    begin
        case (hdr_phase_reg)
            3'd0:    hdr_byte = HDR_DC2;
            3'd1:    hdr_byte = HDR_STAR;
            3'd2:    hdr_byte = hdr_rows[7:0];
            default: hdr_byte = row_bytes_reg[7:0];
        endcase
    end

    assign stat.run_active = active_reg;
    assign stat.header_due = (fill_reg == 16'd0) && (hdr_phase_reg < HDR_LEN);
    assign stat.out_full   = out_valid_reg;
    assign stat.div_busy   = div_busy;
    assign stat.need_read  = need_read;
    assign stat.byte_done  = byte_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg       <= 12'd384;
            img_h_reg       <= 12'd1;
            scale_req_reg   <= 8'd0;
            center_reg      <= 1'b0;
            print_w_reg     <= 12'd384;
            pkg_limit_reg   <= 16'd4096;
            scale_reg       <= '0;
            sw_reg          <= '0;
            printed_reg     <= '0;
            margin_reg      <= '0;
            row_bytes_reg   <= '0;
            pkg_bytes_reg   <= '0;
            pkg_rows_reg    <= '0;
            rows_rem_reg    <= '0;
            src_row_reg     <= '0;
            row_rep_reg     <= '0;
            src_col_reg     <= '0;
            col_rep_reg     <= '0;
            row_dot_reg     <= '0;
            margin_cnt_reg  <= '0;
            margin_done_reg <= 1'b0;
            pack_reg        <= '0;
            bit_off_reg     <= 3'd7;
            fill_reg        <= '0;
            hdr_phase_reg   <= '0;
            active_reg      <= 1'b0;
            row_base_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:   img_w_reg     <= cfg_data[11:0];
                    CFG_IMAGE_HEIGHT:  img_h_reg     <= cfg_data[11:0];
                    CFG_SCALE_REQUEST: scale_req_reg <= cfg_data[7:0];
                    CFG_CENTER_ENABLE: center_reg    <= cfg_data[0];
                    CFG_PRINT_WIDTH:   print_w_reg   <= cfg_data[11:0];
                    CFG_PACKAGE_LIMIT: pkg_limit_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.run_scale)
            begin
                scale_reg <= scale_calc;
            end
            if (cmd.run_mult)
            begin
                sw_reg       <= sw_prod[11:0];
                rows_rem_reg <= (tot_prod > 24'd65535) ? 16'hFFFF : tot_prod[15:0];
            end
            if (cmd.run_geom)
            begin
                margin_reg  <= margin_calc;
                printed_reg <= sw_reg + {1'b0, margin_calc};
            end
            if (cmd.run_rowb)
            begin
                row_bytes_reg <= rb_sum[12:3];
            end
            if (cmd.run_pkg)
            begin
                pkg_rows_reg    <= prow;
                pkg_bytes_reg   <= pkg_prod[15:0];
                src_row_reg     <= '0;
                row_rep_reg     <= '0;
                src_col_reg     <= '0;
                col_rep_reg     <= '0;
                row_dot_reg     <= '0;
                margin_cnt_reg  <= '0;
                margin_done_reg <= 1'b0;
                pack_reg        <= '0;
                bit_off_reg     <= 3'd7;
                fill_reg        <= '0;
                hdr_phase_reg   <= '0;
                active_reg      <= (scale_reg != 12'd0) && (img_h_reg != 12'd0);
            end

            if (cmd.emit_idle)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.emit_header)
            begin
                out_valid_reg <= 1'b1;
                hdr_phase_reg <= hdr_phase_reg + 3'd1;
            end

            if (cmd.row_base)
            begin
                row_base_reg <= src_row_reg * img_w_reg;
            end

            // margin and column advance of the dot being fetched
            if (cmd.dot_step)
            begin
                if (in_margin)
                begin
                    margin_cnt_reg <= margin_cnt_reg + 11'd1;
                end
                else
                begin
                    margin_done_reg <= 1'b1;
                end
                if (need_read)
                begin
                    col_rep_reg <= col_wrap ? 12'd0 : col_rep_inc[11:0];
                    if (col_wrap)
                    begin
                        src_col_reg <= src_col_reg + 12'd1;
                    end
                end
            end

            if (finishing)
            begin
                row_dot_reg <= row_end ? 12'd0 : row_dot_inc[11:0];
                if (row_end)
                begin
                    margin_cnt_reg  <= '0;
                    margin_done_reg <= 1'b0;
                    src_col_reg     <= '0;
                    col_rep_reg     <= '0;
                    row_rep_reg     <= row_wrap ? 12'd0 : row_rep_inc[11:0];
                    src_row_reg     <= src_row_new;
                end
                if (byte_done)
                begin
                    pack_reg      <= '0;
                    bit_off_reg   <= 3'd7;
                    out_valid_reg <= 1'b1;
                    if (pkg_end)
                    begin
                        fill_reg      <= '0;
                        hdr_phase_reg <= '0;
                        rows_rem_reg  <= (rows_rem_reg > pkg_rows_reg)
                                         ? rows_rem_reg - pkg_rows_reg : 16'd0;
                    end
                    else
                    begin
                        fill_reg <= fill_inc[15:0];
                    end
                    if (last)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                else
                begin
                    pack_reg    <= pack_new;
                    bit_off_reg <= bit_off_reg - 3'd1;
                end
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_idle)
        begin
            out_data_reg <= '{out_byte: 8'd0, is_header: 1'b0, run_done: 1'b1};
        end
        else if (cmd.emit_header)
        begin
            out_data_reg <= '{out_byte: hdr_byte, is_header: 1'b1, run_done: 1'b0};
        end
        else if (finishing && byte_done)
        begin
            out_data_reg <= '{out_byte: pack_new, is_header: 1'b0, run_done: last};
        end
    end

    // bitmap store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            store[in_data.load_address] <= in_data.load_data;
        end
        if (cmd.dot_step && need_read)
        begin
            rd_data_reg <= store[bit_idx[STORE_AW+2:3]];
            rd_sel_reg  <= bit_idx[2:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/core/bspc_ctrl.sv
// Controller: sequences loads, start-up geometry, header and idle beats and the per-dot walk.
// Depends on bspc_pkg.
`timescale 1ns / 1ps

module bspc_ctrl
    import bspc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_opcode,
    output logic       in_ready,
    output bspc_cmd_t  cmd,
    input  bspc_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVM_GO,
        S_DIVM_WAIT,
        S_SCALE,
        S_MULT,
        S_GEOM,
        S_ROWB,
        S_DIVP_GO,
        S_DIVP_WAIT,
        S_PKG,
        S_WAIT_OUT,
        S_BASE,
        S_DOT,
        S_DOT_WAIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_opcode)
                        OP_LOAD:  cmd.mem_write = 1'b1;
                        OP_START: state_next = S_DIVM_GO;
                        OP_PULL:  state_next = S_WAIT_OUT;
                        default: ;
                    endcase
                end
            end
            S_DIVM_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVM_WAIT;
            end
            S_DIVM_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.run_scale = 1'b1;
                state_next    = S_MULT;
            end
            S_MULT:
            begin
                cmd.run_mult = 1'b1;
                state_next   = S_GEOM;
            end
            S_GEOM:
            begin
                cmd.run_geom = 1'b1;
                state_next   = S_ROWB;
            end
            S_ROWB:
            begin
                cmd.run_rowb = 1'b1;
                state_next   = S_DIVP_GO;
            end
            S_DIVP_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_pkg   = 1'b1;
                state_next    = S_DIVP_WAIT;
            end
            S_DIVP_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_PKG;
                end
            end
            S_PKG:
            begin
                cmd.run_pkg = 1'b1;
                state_next  = S_IDLE;
            end
            S_WAIT_OUT:
            begin
                if (!stat.out_full)
                begin
                    if (!stat.run_active)
                    begin
                        cmd.emit_idle = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else if (stat.header_due)
                    begin
                        cmd.emit_header = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE:
            begin
                cmd.row_base = 1'b1;
                state_next   = S_DOT;
            end
            S_DOT:
            begin
                cmd.dot_step = 1'b1;
                if (stat.need_read)
                begin
                    state_next = S_DOT_WAIT;
                end
                else if (stat.byte_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DOT_WAIT:
            begin
                cmd.dot_finish = 1'b1;
                state_next     = stat.byte_done ? S_IDLE : S_DOT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/bspc_checker.sv
// Port-level checker for the chunker, attached by bind.
// Depends on bspc_pkg and bitmap_scale_pack_chunker.
`timescale 1ns / 1ps

module bspc_checker
    import bspc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a waiting result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // the done marker never sits on a header byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.run_done |-> !out_data.is_header)
        else $error("done flagged on header byte");

    // a pull occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.opcode == OP_PULL |=> !in_ready)
        else $error("input taken during pull");

    // loads stream without pause
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.opcode == OP_LOAD |=> in_ready)
        else $error("load stalled input");

endmodule

bind bitmap_scale_pack_chunker bspc_checker u_bspc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
